// ===== rtl/dlsh_pkg.sv =====
// dual-lane stream hash: shared types, constants, microcode rom and lane helpers
// no dependencies; imported by dlsh_datapath, dual_lane_stream_hash_top, dlsh_checker, dlsh_digest_checker and tb
`default_nettype none

package dlsh_pkg;

    localparam int PC_W = 6;

    localparam logic [63:0] INIT_FIRST  = 64'h243F6A8885A308D3;
    localparam logic [63:0] INIT_SECOND = 64'h13198A2E03707344;
    localparam logic [63:0] GOLDEN      = 64'h9E3779B97F4A7C15;
    localparam logic [63:0] AVAL_K1     = 64'hFF51AFD7ED558CCD;
    localparam logic [63:0] AVAL_K2     = 64'hC4CEB9FE1A85EC53;
    localparam logic [63:0] MIX_K1      = 64'h3C79AC492BA7B653;
    localparam logic [63:0] MIX_K2      = 64'h1C69B3F74AC4AE35;

    localparam logic [PC_W-1:0] P_ABS = 6'd0;
    localparam logic [PC_W-1:0] P_LEN = 6'd20;
    localparam logic [PC_W-1:0] P_FIN = 6'd21;

    typedef enum logic [1:0] {
        OP_VALUE = 2'd0,
        OP_CHUNK = 2'd1,
        OP_FINAL = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [3:0] {
        A_NONE       = 4'd0,
        A_LANE       = 4'd1,
        A_LEN        = 4'd2,
        A_XS_ACC     = 4'd3,
        A_XS_PROD    = 4'd4,
        A_MIX_FIRST  = 4'd5,
        A_MIX_SECOND = 4'd6,
        A_FIN_FIRST  = 4'd7,
        A_FIN_SECOND = 4'd8
    } acc_op_t;

    typedef enum logic [1:0] {
        M_NONE = 2'd0,
        M_LL   = 2'd1,
        M_HL   = 2'd2,
        M_LH   = 2'd3
    } mul_op_t;

    typedef enum logic [1:0] {
        K_1 = 2'd0,
        K_2 = 2'd1,
        K_3 = 2'd2,
        K_4 = 2'd3
    } k_sel_t;

    typedef enum logic [1:0] {
        ST_NONE   = 2'd0,
        ST_FIRST  = 2'd1,
        ST_SECOND = 2'd2,
        ST_INIT   = 2'd3
    } st_op_t;

    typedef enum logic [1:0] {
        J_NEXT        = 2'd0,
        J_GOTO        = 2'd1,
        J_LEN_OR_DONE = 2'd2,
        J_DONE        = 2'd3
    } jmp_t;

    typedef struct packed {
        acc_op_t         acc;
        mul_op_t         mul;
        k_sel_t          k;
        logic            m_load;
        st_op_t          st;
        logic            len_clr;
        logic            emit;
        jmp_t            jmp;
        logic [PC_W-1:0] target;
    } ctl_t;

    function automatic logic [63:0] k_value(input k_sel_t k);
        logic [63:0] r;
        case (k)
            K_1:     r = AVAL_K1;
            K_2:     r = AVAL_K2;
            K_3:     r = MIX_K1;
            K_4:     r = MIX_K2;
            default: r = AVAL_K1;
        endcase
        return r;
    endfunction

    function automatic logic [63:0] xs33(input logic [63:0] v);
        return v ^ (v >> 33);
    endfunction

    function automatic logic [63:0] rotl(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    function automatic logic [3:0] sat_bytes(input logic [3:0] n);
        return (n > 4'd8) ? 4'd8 : n;
    endfunction

    // short chunk: clear bytes above the valid ones, tag count in the top byte
    function automatic logic [63:0] chunk_lane(input logic [63:0] data, input logic [3:0] n);
        logic [63:0] r;
        r = data;
        if (n < 4'd8)
        begin
            for (int i = 0; i < 8; i++)
            begin
                if (i >= int'(n))
                begin
                    r[8*i +: 8] = 8'h00;
                end
            end
            r[63:56] = r[63:56] ^ {4'h0, n};
        end
        return r;
    endfunction

    // microcode: lane absorb at 0..19, length lane at 20, finalize at 21..40
    function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
        ctl_t w;
        w.acc     = A_NONE;
        w.mul     = M_NONE;
        w.k       = K_1;
        w.m_load  = 1'b0;
        w.st      = ST_NONE;
        w.len_clr = 1'b0;
        w.emit    = 1'b0;
        w.jmp     = J_NEXT;
        w.target  = '0;
        case (pc)
            6'd0:                w.acc = A_LANE;
            6'd1, 6'd22, 6'd32:  w.acc = A_XS_ACC;
            6'd5, 6'd26, 6'd36:  w.acc = A_XS_PROD;
            6'd10:               w.acc = A_MIX_FIRST;
            6'd15:               w.acc = A_MIX_SECOND;
            6'd20:               w.acc = A_LEN;
            6'd21:               w.acc = A_FIN_FIRST;
            6'd31:               w.acc = A_FIN_SECOND;
            default:             w.acc = A_NONE;
        endcase
        case (pc)
            6'd2, 6'd6, 6'd11, 6'd16, 6'd23, 6'd27, 6'd33, 6'd37: w.mul = M_LL;
            6'd3, 6'd7, 6'd12, 6'd17, 6'd24, 6'd28, 6'd34, 6'd38: w.mul = M_HL;
            6'd4, 6'd8, 6'd13, 6'd18, 6'd25, 6'd29, 6'd35, 6'd39: w.mul = M_LH;
            default:                                              w.mul = M_NONE;
        endcase
        case (pc) inside
            [6'd6:6'd8], [6'd27:6'd29], [6'd37:6'd39]: w.k = K_2;
            [6'd11:6'd13]:                             w.k = K_3;
            [6'd16:6'd18]:                             w.k = K_4;
            default:                                   w.k = K_1;
        endcase
        case (pc)
            6'd9, 6'd30: w.m_load = 1'b1;
            default:     w.m_load = 1'b0;
        endcase
        case (pc)
            6'd14:   w.st = ST_FIRST;
            6'd19:   w.st = ST_SECOND;
            6'd40:   w.st = ST_INIT;
            default: w.st = ST_NONE;
        endcase
        case (pc)
            6'd19:
            begin
                w.jmp = J_LEN_OR_DONE;
            end
            6'd20:
            begin
                w.len_clr = 1'b1;
                w.jmp     = J_GOTO;
                w.target  = P_ABS + 6'd1;
            end
            6'd40:
            begin
                w.len_clr = 1'b1;
                w.emit    = 1'b1;
                w.jmp     = J_DONE;
            end
            default:
            begin
                w.jmp = J_NEXT;
            end
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/dlsh_datapath.sv =====
// dual-lane stream hash datapath: hash words, accumulator, shared 32x32 multiplier
// depends on dlsh_pkg; driven one control word per step by dual_lane_stream_hash_top
`default_nettype none

module dlsh_datapath #(
    parameter int LENGTH_BITS = 32
) (
    input  logic           clk,
    input  logic           rst_n,
    input  dlsh_pkg::ctl_t ctl,
    input  logic           step_en,
    input  logic           load_en,
    input  logic [63:0]    load_lane,
    input  logic [3:0]     load_bytes,
    output logic [63:0]    digest_first,
    output logic [63:0]    digest_second
);
    import dlsh_pkg::*;

    logic [63:0]            first_reg, first_next;
    logic [63:0]            second_reg, second_next;
    logic [LENGTH_BITS-1:0] count_reg, count_next;
    logic [63:0]            acc_reg, acc_next;
    logic [63:0]            prod_reg, prod_next;
    logic [63:0]            m_reg, m_next;
    logic [63:0]            lane_reg, lane_next;

    logic [63:0] k_sel;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [63:0] part;

    // one partial product per step
    always_comb
    begin
        k_sel = k_value(ctl.k);
        mul_a = (ctl.mul == M_HL) ? acc_reg[63:32] : acc_reg[31:0];
        mul_b = (ctl.mul == M_LH) ? k_sel[63:32] : k_sel[31:0];
        part  = 64'(mul_a) * 64'(mul_b);
    end

    always_comb
    begin
        acc_next    = acc_reg;
        prod_next   = prod_reg;
        m_next      = m_reg;
        first_next  = first_reg;
        second_next = second_reg;
        count_next  = count_reg;
        lane_next   = lane_reg;
        if (load_en)
        begin
            lane_next  = load_lane;
            count_next = count_reg + LENGTH_BITS'(load_bytes);
        end
        if (step_en)
        begin
            case (ctl.acc)
                A_LANE:       acc_next = lane_reg + GOLDEN;
                A_LEN:        acc_next = 64'(count_reg) + GOLDEN;
                A_XS_ACC:     acc_next = xs33(acc_reg);
                A_XS_PROD:    acc_next = xs33(prod_reg);
                A_MIX_FIRST:  acc_next = rotl(first_reg ^ m_reg, 27);
                A_MIX_SECOND: acc_next = rotl(second_reg + m_reg, 31);
                A_FIN_FIRST:  acc_next = first_reg ^ rotl(second_reg, 17);
                A_FIN_SECOND: acc_next = second_reg ^ rotl(m_reg, 29);
                default:      acc_next = acc_reg;
            endcase
            case (ctl.mul)
                M_LL:    prod_next = part;
                M_HL,
                M_LH:    prod_next = prod_reg + {part[31:0], 32'h0};
                default: prod_next = prod_reg;
            endcase
            if (ctl.m_load)
            begin
                m_next = xs33(prod_reg);
            end
            case (ctl.st)
                ST_FIRST:  first_next = prod_reg + second_reg;
                ST_SECOND: second_next = prod_reg + first_reg;
                ST_INIT:
                begin
                    first_next  = INIT_FIRST;
                    second_next = INIT_SECOND;
                end
                default:   first_next = first_reg;
            endcase
            if (ctl.len_clr)
            begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg  <= INIT_FIRST;
            second_reg <= INIT_SECOND;
            count_reg  <= '0;
        end
        else
        begin
            first_reg  <= first_next;
            second_reg <= second_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        prod_reg <= prod_next;
        m_reg    <= m_next;
        lane_reg <= lane_next;
    end

    assign digest_first  = m_reg;
    assign digest_second = xs33(prod_reg);

endmodule

`default_nettype wire

// ===== rtl/dual_lane_stream_hash_top.sv =====
// dual-lane stream hash top level: stream ports, microcode sequencer, digest register
// depends on dlsh_pkg and dlsh_datapath
//
// A 128-bit hash kept as two 64-bit words, fed one transaction at a time. Every 64-bit
// multiplication runs as three 32x32 partial products on one shared multiplier, stepped
// by a 41-word microcode rom, one word per cycle unless stalled. A chunk that ends a
// string also runs the length lane (alone for an empty string); the input is ready in
// the cycle after the last step. An unused operation or an empty chunk without end mark
// leaves the sequencer idle. A finished digest waits in its own register, so new
// transactions are taken while it is unclaimed; a second finalize holds at its last step
// until the earlier digest is taken.
`default_nettype none

module dual_lane_stream_hash_top #(
    parameter int LENGTH_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // data_word, valid_bytes, zero pad
    input  logic [1:0]   s_axis_tuser,   // operation
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata    // digest_first, digest_second
);
    import dlsh_pkg::*;

    logic            busy_reg, busy_next;
    logic [PC_W-1:0] pc_reg, pc_next;
    logic            len_pending_reg, len_pending_next;
    logic            out_valid_reg, out_valid_next;
    logic [63:0]     out_first_reg, out_first_next;
    logic [63:0]     out_second_reg, out_second_next;

    ctl_t        ctl;
    logic        in_accept;
    op_t         in_op;
    logic [63:0] in_data;
    logic [3:0]  in_bytes;
    logic        step_en;
    logic [63:0] load_lane;
    logic [3:0]  load_bytes;
    logic [63:0] dig_first;
    logic [63:0] dig_second;

    assign ctl       = ucode(pc_reg);
    assign in_accept = s_axis_tvalid & s_axis_tready;
    assign in_op     = op_t'(s_axis_tuser);
    assign in_data   = s_axis_tdata[63:0];
    assign in_bytes  = sat_bytes(s_axis_tdata[67:64]);

    assign s_axis_tready = ~busy_reg;
    assign step_en       = busy_reg & ~(ctl.emit & out_valid_reg & ~m_axis_tready);

    assign load_lane  = (in_op == OP_CHUNK) ? chunk_lane(in_data, in_bytes) : in_data;
    assign load_bytes = (in_op == OP_CHUNK) ? in_bytes : 4'd0;

    dlsh_datapath #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .step_en       (step_en),
        .load_en       (in_accept),
        .load_lane     (load_lane),
        .load_bytes    (load_bytes),
        .digest_first  (dig_first),
        .digest_second (dig_second)
    );

    // sequencer
    always_comb
    begin
        busy_next        = busy_reg;
        pc_next          = pc_reg;
        len_pending_next = len_pending_reg;
        if (in_accept)
        begin
            case (in_op)
                OP_VALUE:
                begin
                    busy_next        = 1'b1;
                    pc_next          = P_ABS;
                    len_pending_next = 1'b0;
                end
                OP_CHUNK:
                begin
                    len_pending_next = s_axis_tlast;
                    if (in_bytes != 4'd0)
                    begin
                        busy_next = 1'b1;
                        pc_next   = P_ABS;
                    end
                    else if (s_axis_tlast)
                    begin
                        busy_next = 1'b1;
                        pc_next   = P_LEN;
                    end
                end
                OP_FINAL:
                begin
                    busy_next        = 1'b1;
                    pc_next          = P_FIN;
                    len_pending_next = 1'b0;
                end
                default:
                begin
                    busy_next = busy_reg;
                end
            endcase
        end
        else if (step_en)
        begin
            if (ctl.len_clr)
            begin
                len_pending_next = 1'b0;
            end
            case (ctl.jmp)
                J_NEXT: pc_next = pc_reg + 6'd1;
                J_GOTO: pc_next = ctl.target;
                J_LEN_OR_DONE:
                begin
                    if (len_pending_reg)
                    begin
                        pc_next = P_LEN;
                    end
                    else
                    begin
                        busy_next = 1'b0;
                    end
                end
                default: busy_next = 1'b0;
            endcase
        end
    end

    // digest register
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_first_next  = out_first_reg;
        out_second_next = out_second_reg;
        if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        if (step_en & ctl.emit)
        begin
            out_valid_next  = 1'b1;
            out_first_next  = dig_first;
            out_second_next = dig_second;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg        <= 1'b0;
            pc_reg          <= P_ABS;
            len_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            busy_reg        <= busy_next;
            pc_reg          <= pc_next;
            len_pending_reg <= len_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_first_reg  <= out_first_next;
        out_second_reg <= out_second_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_second_reg, out_first_reg};

endmodule

`default_nettype wire

// ===== rtl/dlsh_checker.sv =====
// dual-lane stream hash port checker and its bind to the top level
// depends on dlsh_pkg and dual_lane_stream_hash_top
`default_nettype none

module dlsh_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic [1:0]   s_axis_tuser,   // operation
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [127:0] m_axis_tdata    // digest_first, digest_second
);
    import dlsh_pkg::*;

    logic in_accept;
    assign in_accept = s_axis_tvalid & s_axis_tready;

    // digest held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("digest dropped before transaction");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("digest changed while stalled");

    // finalize and value absorb occupy the sequencer
    a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && (s_axis_tuser == OP_FINAL || s_axis_tuser == OP_VALUE)
        |=> !s_axis_tready)
        else $error("input ready while hash step in progress");

    // unused operation is a no-op
    a_none_ready: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tuser == OP_NONE |=> s_axis_tready)
        else $error("unused operation stalled the input");

    // a digest only appears at the end of a sequencer run
    a_digest_origin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
        else $error("digest without a finalize run");

endmodule

bind dual_lane_stream_hash_top dlsh_checker u_dlsh_checker (.*);

`default_nettype wire

// ===== dv/dlsh_digest_checker.sv =====
// dual-lane stream hash checker: watches both stream channels, predicts digests, compares
// depends on dlsh_pkg for the operation codes and the hash constants
`default_nettype none

module dlsh_digest_checker #(
    parameter int LENGTH_BITS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [71:0]  s_axis_tdata,   // data_word, valid_bytes, zero pad
    input  logic [1:0]   s_axis_tuser,   // operation
    input  logic         s_axis_tlast,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [127:0] m_axis_tdata,   // digest_first, digest_second
    output int           mismatches,
    output int           pending,
    output int           digests_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    import dlsh_pkg::*;

    localparam int FIFO_DEPTH = 16;

    typedef struct packed {
        logic [63:0] second;
        logic [63:0] first;
    } digest_t;

    digest_t                expected_digests[FIFO_DEPTH];
    logic [3:0]             wr_ptr;
    logic [3:0]             rd_ptr;
    int                     fill;
    logic [63:0]            hash_a;
    logic [63:0]            hash_b;
    logic [LENGTH_BITS-1:0] string_len;
    int                     err_count;
    int                     seen_count;

    function automatic logic [63:0] fold33(input logic [63:0] v);
        return v ^ {33'd0, v[63:33]};
    endfunction

    function automatic logic [63:0] finisher(input logic [63:0] v);
        logic [63:0] t;
        t = fold33(v) * AVAL_K1;
        t = fold33(t) * AVAL_K2;
        return fold33(t);
    endfunction

    function automatic logic [63:0] rotate_left(input logic [63:0] v, input int r);
        return (v << r) | (v >> (64 - r));
    endfunction

    task automatic absorb_lane(input logic [63:0] lane);
        logic [63:0] m;
        m      = finisher(lane + GOLDEN);
        hash_a = rotate_left(hash_a ^ m, 27) * MIX_K1 + hash_b;
        hash_b = rotate_left(hash_b + m, 31) * MIX_K2 + hash_a;
    endtask

    task automatic take_transaction(input op_t op, input logic [63:0] data,
                                    input logic [3:0] nbytes, input logic eos);
        logic [3:0]  n;
        logic [63:0] lane;
        digest_t     d;
        case (op)
            OP_VALUE:
            begin
                absorb_lane(data);
            end
            OP_CHUNK:
            begin
                n = (nbytes > 4'd8) ? 4'd8 : nbytes;
                if (n == 4'd8)
                begin
                    absorb_lane(data);
                end
                else if (n != 4'd0)
                begin
                    lane = data & ((64'd1 << (8 * n)) - 64'd1);
                    lane[63:56] = lane[63:56] ^ {4'h0, n};
                    absorb_lane(lane);
                end
                string_len = string_len + LENGTH_BITS'(n);
                if (eos)
                begin
                    absorb_lane(64'(string_len));
                    string_len = '0;
                end
            end
            OP_FINAL:
            begin
                d.first  = finisher(hash_a ^ rotate_left(hash_b, 17));
                d.second = finisher(hash_b ^ rotate_left(d.first, 29));
                if (fill == FIFO_DEPTH)
                begin
                    $error("expected digest store overflowed");
                    err_count++;
                end
                else
                begin
                    expected_digests[wr_ptr] = d;
                    wr_ptr = wr_ptr + 4'd1;
                    fill++;
                end
                hash_a     = INIT_FIRST;
                hash_b     = INIT_SECOND;
                string_len = '0;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        digest_t got;
        digest_t want;
        if (!rst_n)
        begin
            hash_a     = INIT_FIRST;
            hash_b     = INIT_SECOND;
            string_len = '0;
            err_count  = 0;
            seen_count = 0;
            wr_ptr     = '0;
            rd_ptr     = '0;
            fill       = 0;
            mismatches      <= 0;
            pending         <= 0;
            digests_checked <= 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                take_transaction(op_t'(s_axis_tuser), s_axis_tdata[63:0],
                                 s_axis_tdata[67:64], s_axis_tlast);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                got = m_axis_tdata;
                if (fill == 0)
                begin
                    $error("digest %h_%h arrived with none expected", got.second, got.first);
                    err_count++;
                end
                else
                begin
                    want = expected_digests[rd_ptr];
                    rd_ptr = rd_ptr + 4'd1;
                    fill--;
                    seen_count++;
                    if (got.first !== want.first)
                    begin
                        $error("digest_first: expected %h, got %h", want.first, got.first);
                        err_count++;
                    end
                    if (got.second !== want.second)
                    begin
                        $error("digest_second: expected %h, got %h", want.second, got.second);
                        err_count++;
                    end
                end
            end
            mismatches      <= err_count;
            pending         <= fill;
            digests_checked <= seen_count;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// dual-lane stream hash testbench top: clock, reset, stimulus, output stalls and verdict
// depends on dlsh_pkg, dual_lane_stream_hash_top and dlsh_digest_checker
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dlsh_pkg::*;

    localparam int RANDOM_ITEMS = 1900;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [71:0]  s_axis_tdata;   // data_word, valid_bytes, zero pad
    logic [1:0]   s_axis_tuser;   // operation
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [127:0] m_axis_tdata;   // digest_first, digest_second

    int mismatches;
    int pending;
    int digests_checked;
    int items_sent;
    int op_counts[4];
    bit idle_on;

    dual_lane_stream_hash_top #(
        .LENGTH_BITS(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    dlsh_digest_checker #(
        .LENGTH_BITS(32)
    ) checker_inst (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .mismatches(mismatches),
        .pending(pending),
        .digests_checked(digests_checked)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input op_t op, input logic [63:0] data,
                             input logic [3:0] nbytes, input logic eos);
        int gap;
        gap = idle_on ? $urandom_range(0, 3) : 0;
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tdata  <= {4'h0, nbytes, data};
        s_axis_tuser  <= op;
        s_axis_tlast  <= eos;
        s_axis_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!(s_axis_tvalid && s_axis_tready));
        items_sent++;
        op_counts[op]++;
    endtask

    task automatic send_value(input logic [63:0] v);
        send_item(OP_VALUE, v, 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    task automatic send_final();
        send_item(OP_FINAL, rand_word(), 4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    endtask

    // chunks of eight with a short tail; the chunk that empties the string carries the end mark
    task automatic send_string(input int len);
        int         remaining;
        int         take;
        logic [3:0] nb;
        remaining = len;
        do
        begin
            take = (remaining > 8) ? 8 : remaining;
            remaining -= take;
            nb = 4'(take);
            if (take == 8 && $urandom_range(0, 5) == 0)
            begin
                nb = 4'($urandom_range(9, 15));
            end
            send_item(OP_CHUNK, rand_word(), nb, remaining == 0);
        end
        while (remaining > 0);
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 4))
            0: send_item(OP_NONE, rand_word(), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
            1: send_item(OP_CHUNK, rand_word(), 4'($urandom_range(1, 7)), 1'b0);
            2: send_item(OP_CHUNK, rand_word(), 4'($urandom_range(0, 15)),
                         1'($urandom_range(0, 1)));
            3: send_item(OP_CHUNK, rand_word(), 4'd0, 1'b0);
            default: send_value(rand_word());
        endcase
    endtask

    // header words, a few byte strings, then finalize; some records are cut short or noisy
    task automatic send_record();
        int strings;
        if ($urandom_range(0, 3) != 0)
        begin
            send_value(($urandom_range(0, 1) != 0) ? 64'h5452414E53504F52 : rand_word());
            send_value(64'($urandom_range(0, 7)));
            send_value(64'($urandom_range(1, 4096)));
            send_value(64'($urandom_range(1, 4096)));
            send_value(64'($urandom_range(1, 16384)));
            send_value(($urandom_range(0, 3) == 0) ? rand_word() : 64'($urandom));
        end
        strings = $urandom_range(0, 3);
        repeat (strings)
        begin
            if ($urandom_range(0, 7) == 0)
            begin
                send_noise();
            end
            send_string(($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 40));
        end
        if ($urandom_range(0, 9) != 0)
        begin
            send_final();
        end
    endtask

    initial
    begin : receiver
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = idle_on ? $urandom_range(0, 3) : 0;
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do
                @(posedge clk);
            while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    initial
    begin : stimulus
        int records;
        int limit;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_VALUE;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        items_sent    = 0;
        idle_on       = 1'b0;
        records       = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_FINAL, 64'd0, 4'd0, 1'b0);
        send_item(OP_VALUE, 64'd0, 4'd0, 1'b0);
        send_item(OP_VALUE, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1);
        send_item(OP_CHUNK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0);
        send_item(OP_CHUNK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd3, 1'b1);
        send_item(OP_FINAL, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1);
        send_item(OP_CHUNK, 64'h0123_4567_89AB_CDEF, 4'd7, 1'b0);
        send_item(OP_CHUNK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd1, 1'b1);
        send_item(OP_CHUNK, 64'd0, 4'd0, 1'b1);
        send_item(OP_CHUNK, 64'hA5A5_A5A5_A5A5_A5A5, 4'd0, 1'b0);
        send_item(OP_CHUNK, 64'h5A5A_5A5A_5A5A_5A5A, 4'd12, 1'b0);
        send_item(OP_CHUNK, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1);
        send_item(OP_CHUNK, 64'd0, 4'd9, 1'b1);
        send_item(OP_NONE, 64'hFFFF_FFFF_FFFF_FFFF, 4'hF, 1'b1);
        send_item(OP_FINAL, 64'd0, 4'd0, 1'b0);
        send_item(OP_FINAL, 64'd0, 4'd0, 1'b0);
        send_item(OP_VALUE, 64'h5452414E53504F52, 4'd0, 1'b0);
        send_item(OP_CHUNK, 64'h8000_0000_0000_0001, 4'd2, 1'b0);
        send_item(OP_FINAL, 64'd0, 4'd0, 1'b0);

        limit = items_sent + RANDOM_ITEMS;
        while (items_sent < limit)
        begin
            idle_on = ($urandom_range(0, 3) != 0);
            send_record();
            records++;
            if (records % 25 == 0)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);

        $display("sent %0d transactions in %0d records:", items_sent, records);
        $display("  %0d value, %0d chunk, %0d finalize, %0d unused",
                 op_counts[OP_VALUE], op_counts[OP_CHUNK],
                 op_counts[OP_FINAL], op_counts[OP_NONE]);
        $display("compared %0d digests, %0d mismatches", digests_checked, mismatches);
        if (mismatches == 0 && pending == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
